// ----- hdl/hcb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// hcb_pkg: shared types for the code builder
// controller states and the command/status words between control and datapath
// ============================================================================
package hcb_pkg;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_MERGE,
        ST_PREP,
        ST_EMIT
    } hcb_state_t;

    typedef struct packed {
        logic load;       // write the start word into the next leaf slot
        logic scan_clr;   // clear the running best pair and scan index
        logic scan_step;  // compare one node against the best pair
        logic merge;      // create the merged node
        logic prep_step;  // prepend one bit to one leaf
        logic emit_clr;   // restart emit index
        logic emit_step;  // emit one leaf
        logic finish;     // clear block state
    } hcb_cmd_t;

    typedef struct packed {
        logic load_done;  // loaded count plus this word reaches the effective count
        logic scan_end;   // scan index past last node, no read pending
        logic one_live;   // only one live node remains
        logic prep_end;   // leaf index past last leaf
        logic emit_end;   // emitting the final leaf
    } hcb_stat_t;

endpackage
`default_nettype wire

// ----- hdl/huffman_code_builder_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// huffman_code_builder_core: builds prefix codes from symbol frequencies
// loads one frequency per word, then merges and emits one code per symbol
// ============================================================================
// a frequency word is taken on each edge with start high and busy low, one
// per cycle. the word that completes the block starts construction: each of
// the n-1 merges scans the node table through a registered read (one node per
// cycle, then the read drains), creates the merged node, then updates the
// leaf codes (one leaf per cycle); afterwards n result words follow, one per
// cycle, each shown for one cycle with strobe high. the receiver cannot
// stall, so results must be taken as they come. busy rises after the final
// frequency word and falls in the cycle that shows the last result word.
// symbol_count is written by cfg_we and is saturated to 2..MAX_SYMBOLS.
module huffman_code_builder_core
    import hcb_pkg::*;
#(
    parameter int MAX_SYMBOLS = 32,
    parameter int FREQ_BITS   = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [FREQ_BITS-1:0] frequency,
    input  wire logic                 cfg_we,
    input  wire logic [5:0]           cfg_data,
    output logic                      strobe,
    output logic [5:0]                symbol,
    output logic [4:0]                code_length,
    output logic [30:0]               code,
    output logic                      last
);

    logic [5:0] count_reg;
    logic [5:0] count_eff;
    hcb_cmd_t   cmd;
    hcb_stat_t  stat;

    // symbol count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 6'd2;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_data;
        end
    end

    // saturate to the legal range
    always_comb
    begin
        if (count_reg < 6'd2)
        begin
            count_eff = 6'd2;
        end
        else if (7'(count_reg) > 7'(MAX_SYMBOLS))
        begin
            count_eff = 6'(MAX_SYMBOLS);
        end
        else
        begin
            count_eff = count_reg;
        end
    end

    hcb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    hcb_datapath #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .FREQ_BITS   (FREQ_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .frequency   (frequency),
        .count_eff   (count_eff),
        .cmd         (cmd),
        .stat        (stat),
        .strobe      (strobe),
        .symbol      (symbol),
        .code_length (code_length),
        .code        (code),
        .last        (last)
    );

endmodule
`default_nettype wire

// ----- hdl/hcb_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// hcb_ctrl: controller
// sequences loading, scanning, merging, code update and emitting
// ============================================================================
module hcb_ctrl
    import hcb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  hcb_stat_t      stat,
    output hcb_cmd_t       cmd
);

    hcb_state_t state_reg;
    hcb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (start && stat.load_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.one_live)
                begin
                    state_next = ST_EMIT;
                end
                else if (stat.scan_end)
                begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                if (stat.prep_end)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_EMIT:
            begin
                if (stat.emit_end)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_LOAD:
            begin
                busy         = 1'b0;
                cmd.load     = start;
                cmd.scan_clr = 1'b1;
                cmd.emit_clr = 1'b1;
            end
            ST_SCAN:
            begin
                if (!stat.one_live)
                begin
                    cmd.scan_step = !stat.scan_end;
                end
                cmd.emit_clr = 1'b1;
            end
            ST_MERGE:
            begin
                cmd.merge = 1'b1;
            end
            ST_PREP:
            begin
                cmd.prep_step = !stat.prep_end;
                cmd.scan_clr  = stat.prep_end;
            end
            ST_EMIT:
            begin
                cmd.emit_step = 1'b1;
                cmd.finish    = stat.emit_end;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/hcb_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// hcb_datapath: node table, leaf codes and result registers
// one node compared or one leaf updated per cycle
// ============================================================================
module hcb_datapath
    import hcb_pkg::*;
#(
    parameter int MAX_SYMBOLS = 32,
    parameter int FREQ_BITS   = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [FREQ_BITS-1:0] frequency,
    input  wire logic [5:0]           count_eff,
    input  hcb_cmd_t                  cmd,
    output hcb_stat_t                 stat,
    output logic                      strobe,
    output logic [5:0]                symbol,
    output logic [4:0]                code_length,
    output logic [30:0]               code,
    output logic                      last
);

    localparam int NODES = 2 * MAX_SYMBOLS - 1;
    localparam int NB    = $clog2(NODES + 1);
    localparam int LB    = $clog2(MAX_SYMBOLS + 1);
    localparam int WB    = FREQ_BITS + $clog2(MAX_SYMBOLS);
    localparam int KB    = $clog2(MAX_SYMBOLS + 1);
    localparam int CB    = (MAX_SYMBOLS > 31) ? MAX_SYMBOLS : 31;
    localparam int NI    = $clog2(NODES);
    localparam int LI    = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

    // node table memory
    logic [WB-1:0] weight_mem [NODES];
    logic [KB-1:0] key_mem    [NODES];
    logic [NODES-1:0] alive_reg;

    logic [NI-1:0] group_mem [MAX_SYMBOLS];
    logic [CB-1:0] code_mem  [MAX_SYMBOLS];
    logic [7:0]    len_mem   [MAX_SYMBOLS];

    logic [LB-1:0] loaded_reg;
    logic [NB-1:0] total_reg;
    logic [LB-1:0] live_reg;
    logic [NB-1:0] idx_reg;
    logic          a_ok_reg, b_ok_reg;
    logic [NI-1:0] a_reg, b_reg;
    logic [WB-1:0] aw_reg, bw_reg;
    logic [KB-1:0] ak_reg, bk_reg;
    logic [LB-1:0] out_reg;

    // registered node read for the scan
    logic          rd_vld_reg;
    logic [NI-1:0] cidx_reg;
    logic [WB-1:0] cw_reg;
    logic [KB-1:0] ck_reg;

    logic [NI-1:0] idx_i;
    logic [WB-1:0] cw;
    logic [KB-1:0] ck;
    logic          lt_a, lt_b;
    logic          scan_rd;
    logic          scan_cmp;
    logic [LI-1:0] ld_i;
    logic [LB-1:0] lcnt_sat;

    assign idx_i    = idx_reg[NI-1:0];
    assign cw       = cw_reg;
    assign ck       = ck_reg;
    assign scan_rd  = cmd.scan_step && (idx_reg < total_reg);
    assign scan_cmp = rd_vld_reg && alive_reg[cidx_reg];
    assign lt_a  = !a_ok_reg || (cw < aw_reg) || (cw == aw_reg && ck < ak_reg);
    assign lt_b  = !b_ok_reg || (cw < bw_reg) || (cw == bw_reg && ck < bk_reg);

    // clamp the write slot to the final leaf
    assign lcnt_sat = (loaded_reg >= LB'(MAX_SYMBOLS)) ? LB'(MAX_SYMBOLS - 1) : loaded_reg;
    assign ld_i     = lcnt_sat[LI-1:0];

    assign stat.load_done = ({{(8-LB){1'b0}}, lcnt_sat} + 8'd1) >= {2'b00, count_eff};
    assign stat.scan_end  = (idx_reg >= total_reg) && !rd_vld_reg;
    assign stat.one_live  = live_reg <= LB'(1);
    assign stat.prep_end  = idx_reg >= NB'(loaded_reg);
    assign stat.emit_end  = (out_reg + LB'(1)) >= loaded_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg  <= '0;
            loaded_reg <= '0;
            total_reg  <= '0;
            live_reg   <= '0;
            idx_reg    <= '0;
            a_ok_reg   <= 1'b0;
            b_ok_reg   <= 1'b0;
            out_reg    <= '0;
            strobe     <= 1'b0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            strobe     <= cmd.emit_step;
            rd_vld_reg <= scan_rd;
            if (cmd.load)
            begin
                alive_reg[ld_i] <= 1'b1;
                loaded_reg      <= lcnt_sat + LB'(1);
                total_reg       <= NB'(lcnt_sat) + NB'(1);
                live_reg        <= lcnt_sat + LB'(1);
            end
            if (cmd.scan_clr)
            begin
                idx_reg  <= '0;
                a_ok_reg <= 1'b0;
                b_ok_reg <= 1'b0;
            end
            if (scan_rd)
            begin
                idx_reg <= idx_reg + NB'(1);
            end
            if (scan_cmp)
            begin
                if (lt_a)
                begin
                    b_ok_reg <= a_ok_reg;
                    a_ok_reg <= 1'b1;
                end
                else if (lt_b)
                begin
                    b_ok_reg <= 1'b1;
                end
            end
            if (cmd.merge)
            begin
                // new node goes live, both children retire
                alive_reg <= (alive_reg | (NODES'(1) << total_reg[NI-1:0]))
                             & ~(NODES'(1) << a_reg) & ~(NODES'(1) << b_reg);
                total_reg <= total_reg + NB'(1);
                live_reg  <= live_reg - LB'(1);
                idx_reg   <= '0;
            end
            if (cmd.prep_step)
            begin
                idx_reg <= idx_reg + NB'(1);
            end
            if (cmd.emit_clr)
            begin
                out_reg <= '0;
            end
            if (cmd.emit_step)
            begin
                out_reg <= out_reg + LB'(1);
            end
            if (cmd.finish)
            begin
                alive_reg  <= '0;
                loaded_reg <= '0;
                total_reg  <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            weight_mem[ld_i] <= WB'(frequency);
            key_mem[ld_i]    <= KB'(lcnt_sat) + KB'(1);
            group_mem[ld_i]  <= NI'(ld_i);
            code_mem[ld_i]   <= '0;
            len_mem[ld_i]    <= '0;
        end
        if (scan_rd)
        begin
            cw_reg   <= weight_mem[idx_i];
            ck_reg   <= key_mem[idx_i];
            cidx_reg <= idx_i;
        end
        if (scan_cmp)
        begin
            if (lt_a)
            begin
                b_reg  <= a_reg;
                bw_reg <= aw_reg;
                bk_reg <= ak_reg;
                a_reg  <= cidx_reg;
                aw_reg <= cw;
                ak_reg <= ck;
            end
            else if (lt_b)
            begin
                b_reg  <= cidx_reg;
                bw_reg <= cw;
                bk_reg <= ck;
            end
        end
        if (cmd.merge)
        begin
            weight_mem[total_reg[NI-1:0]] <= aw_reg + bw_reg;
            key_mem[total_reg[NI-1:0]]    <= (ak_reg < bk_reg) ? ak_reg : bk_reg;
        end
        if (cmd.prep_step)
        begin
            if (group_mem[idx_reg[LI-1:0]] == a_reg || group_mem[idx_reg[LI-1:0]] == b_reg)
            begin
                if (group_mem[idx_reg[LI-1:0]] == b_reg && len_mem[idx_reg[LI-1:0]] < 8'(CB))
                begin
                    code_mem[idx_reg[LI-1:0]] <= code_mem[idx_reg[LI-1:0]]
                        | (CB'(1) << len_mem[idx_reg[LI-1:0]]);
                end
                len_mem[idx_reg[LI-1:0]]   <= len_mem[idx_reg[LI-1:0]] + 8'd1;
                group_mem[idx_reg[LI-1:0]] <= total_reg[NI-1:0] - NI'(1);
            end
        end
        if (cmd.emit_step)
        begin
            symbol      <= 6'(out_reg) + 6'd1;
            code_length <= len_mem[out_reg[LI-1:0]][4:0];
            code        <= code_mem[out_reg[LI-1:0]][30:0];
            last        <= stat.emit_end;
        end
    end

endmodule
`default_nettype wire

// ----- tb/sv/tb_huffman_code_builder_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_huffman_code_builder_core: self-checking bench for the code builder
// drives frequency words under random gaps, predicts every symbol code and
// compares each strobed result word field by field
// ============================================================================
module tb_huffman_code_builder_core;

    localparam int MAX_SYM  = 32;
    localparam int SLOTS    = 2 * MAX_SYM - 1;
    localparam int N_RANDOM = 270;
    // longest construction: 31 merges with scans of up to 62 nodes plus 32-leaf updates
    localparam int DRAIN_CYCLES = 4000;

    typedef struct {
        logic [5:0]  symbol;
        logic [4:0]  code_length;
        logic [30:0] code;
        logic        last;
    } code_word_t;

    // directed row: a count change or a frequency, with an optional typed result
    typedef struct {
        bit          set_count;
        logic [5:0]  value;
        bit          typed;
        logic [4:0]  len_typed;
        logic [30:0] code_typed;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic [15:0] frequency;
    logic        cfg_we;
    logic [5:0]  cfg_data;
    wire         busy;
    wire         strobe;
    wire  [5:0]  symbol;
    wire  [4:0]  code_length;
    wire  [30:0] code;
    wire         last;

    // predictor state
    logic [5:0]  count_reg;
    logic [20:0] wt [SLOTS];
    logic [5:0]  key [SLOTS];
    bit          alive [SLOTS];
    int          group [MAX_SYM];
    logic [63:0] lcode [MAX_SYM];
    int          llen [MAX_SYM];
    int          loaded;
    int          nodes;

    code_word_t  pending_codes[$];
    int          errors;
    dir_row_t    rows[$];

    huffman_code_builder_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .frequency   (frequency),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .strobe      (strobe),
        .symbol      (symbol),
        .code_length (code_length),
        .code        (code),
        .last        (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit node_before(int a, int b);
        if (wt[a] != wt[b])
            return wt[a] < wt[b];
        return key[a] < key[b];
    endfunction

    // merge the two lightest live nodes until one is left, then queue results
    task automatic build_codes();
        int n;
        int live;
        int a;
        int b;
        int nn;
        code_word_t w;
        n = loaded;
        live = n;
        while (live > 1 && nodes < SLOTS)
        begin
            a = -1;
            b = -1;
            for (int i = 0; i < nodes; i++)
            begin
                if (!alive[i])
                    continue;
                if (a < 0 || node_before(i, a))
                begin
                    b = a;
                    a = i;
                end
                else if (b < 0 || node_before(i, b))
                    b = i;
            end
            if (b < 0)
                break;
            nn = nodes;
            wt[nn] = wt[a] + wt[b];
            key[nn] = (key[a] < key[b]) ? key[a] : key[b];
            alive[nn] = 1;
            alive[a] = 0;
            alive[b] = 0;
            for (int i = 0; i < n; i++)
            begin
                if (group[i] == a || group[i] == b)
                begin
                    if (group[i] == b && llen[i] < 64)
                        lcode[i] |= 64'd1 << llen[i];
                    llen[i]++;
                    group[i] = nn;
                end
            end
            nodes++;
            live--;
        end
        for (int i = 0; i < n; i++)
        begin
            w.symbol = 6'(i + 1);
            w.code_length = 5'(llen[i]);
            w.code = lcode[i][30:0];
            w.last = (i + 1 == n);
            pending_codes.push_back(w);
        end
        for (int i = 0; i < SLOTS; i++)
            alive[i] = 0;
        loaded = 0;
        nodes = 0;
    endtask

    // account for one accepted frequency word
    task automatic load_frequency(logic [15:0] f);
        int idx;
        int eff;
        idx = (loaded >= MAX_SYM) ? MAX_SYM - 1 : loaded;
        wt[idx] = {5'd0, f};
        key[idx] = 6'(idx + 1);
        alive[idx] = 1;
        group[idx] = idx;
        lcode[idx] = '0;
        llen[idx] = 0;
        loaded = idx + 1;
        nodes = loaded;
        eff = count_reg;
        if (eff < 2)
            eff = 2;
        if (eff > MAX_SYM)
            eff = MAX_SYM;
        if (loaded >= eff)
            build_codes();
    endtask

    // start stays high into a zero gap; wait_idle drops it after the last word
    task automatic send_frequency(logic [15:0] f, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        frequency <= f;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        load_frequency(f);
    endtask

    // wait for every expected word, then let a possible construction finish
    task automatic wait_idle();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (pending_codes.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // only written with no block in flight (loaded == 0)
    task automatic write_count(logic [5:0] v);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        count_reg = v;
    endtask

    task automatic add_row(bit c, logic [5:0] v, bit t = 0, logic [4:0] l = 0,
                           logic [30:0] cd = 0);
        dir_row_t r;
        r.set_count = c;
        r.value = v;
        r.typed = t;
        r.len_typed = l;
        r.code_typed = cd;
        rows.push_back(r);
    endtask

    // result monitor: one word per strobe, compared with the oldest expectation
    always @(posedge clk)
    begin
        code_word_t e;
        if (rst_n && strobe)
        begin
            if (pending_codes.size() == 0)
            begin
                $display("%0t: unexpected word sym=%0d len=%0d code=%h", $time,
                         symbol, code_length, code);
                errors++;
            end
            else
            begin
                e = pending_codes.pop_front();
                if (symbol !== e.symbol || code_length !== e.code_length ||
                    code !== e.code || last !== e.last)
                begin
                    $display("%0t: mismatch exp sym=%0d len=%0d code=%h last=%0d",
                             $time, e.symbol, e.code_length, e.code, e.last);
                    $display("%0t:          act sym=%0d len=%0d code=%h last=%0d",
                             $time, symbol, code_length, code, last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int eff;
        int burst;
        int sent;
        logic [15:0] f;
        errors = 0;
        rst_n = 1'b0;
        start = 1'b0;
        frequency = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        count_reg = 6'd2;
        loaded = 0;
        nodes = 0;
        for (int i = 0; i < SLOTS; i++)
            alive[i] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: reset count 2 gives codes 0 and 1 of length one
        add_row(0, 6'd0);
        add_row(0, 6'd0, 1, 5'd1, 31'd1);
        add_row(0, 6'd63);
        add_row(0, 6'd63, 1, 5'd1, 31'd1);
        // count below two saturates to two
        add_row(1, 6'd0);
        add_row(0, 6'd5);
        add_row(0, 6'd1);
        add_row(1, 6'd1);
        add_row(0, 6'd7);
        add_row(0, 6'd7);
        // three symbols with a tie, then count above the limit
        add_row(1, 6'd3);
        add_row(0, 6'd4);
        add_row(0, 6'd4);
        add_row(0, 6'd4);
        add_row(1, 6'd63);
        for (int i = 0; i < 32; i++)
            add_row(0, (i % 3 == 0) ? 6'd0 : 6'(i));
        add_row(1, 6'd32);
        foreach (rows[i])
        begin
            if (rows[i].set_count)
            begin
                wait_idle();
                write_count(rows[i].value);
            end
            else
            begin
                f = (rows[i].value == 6'd63) ? 16'hffff : {10'd0, rows[i].value};
                send_frequency(f, $urandom_range(0, 3));
                // typed rows close a two-symbol block: the larger key gets the 1
                if (rows[i].typed && pending_codes.size() != 0 &&
                    (pending_codes[pending_codes.size() - 1].code_length
                         != rows[i].len_typed ||
                     pending_codes[pending_codes.size() - 1].code
                         != rows[i].code_typed))
                begin
                    $display("%0t: mismatch exp len=%0d code=%h act len=%0d code=%h",
                             $time, rows[i].len_typed, rows[i].code_typed,
                             pending_codes[pending_codes.size() - 1].code_length,
                             pending_codes[pending_codes.size() - 1].code);
                    errors++;
                end
            end
        end
        wait_idle();

        // random blocks: full sequences of random count and weight spread
        sent = 0;
        while (sent < N_RANDOM)
        begin
            eff = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 63)
                                              : $urandom_range(0, 8);
            write_count(6'(eff));
            if (eff < 2)
                eff = 2;
            if (eff > MAX_SYM)
                eff = MAX_SYM;
            burst = $urandom_range(0, 3);
            for (int i = 0; i < eff; i++)
            begin
                case (burst)
                    0: f = 16'($urandom);
                    1: f = 16'($urandom_range(0, 3));
                    2: f = 16'($urandom_range(0, 1) ? 16'hffff : $urandom_range(0, 16));
                    default: f = 16'(1 << $urandom_range(0, 15));
                endcase
                send_frequency(f, ($urandom_range(0, 3) == 0) ? 0
                                                               : $urandom_range(0, 12));
                sent++;
            end
            wait_idle();
        end

        wait_idle();
        repeat (DRAIN_CYCLES / 40) @(posedge clk);
        if (errors == 0 && pending_codes.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
